### hw/rtl/ckat_pkg.sv
// shared types and constants for the client keepalive aging table
// no dependencies; compiled first

package ckat_pkg;

    localparam int ADDR_W            = 32;
    localparam int PORT_W            = 16;
    localparam int TIME_W            = 32;
    localparam int PADDR_W           = 3;
    localparam int PDATA_W           = 32;
    localparam int TABLE_ENTRIES_DEF = 16;

    localparam logic [TIME_W-1:0] PING_INTERVAL_RST = 32'd500;
    localparam logic [TIME_W-1:0] TIMEOUT_LIMIT_RST = 32'd5000;

    typedef enum logic [2:0] {
        EV_CONNECTED = 3'd0,
        EV_REFRESHED = 3'd1,
        EV_DROPPED   = 3'd2,
        EV_PING      = 3'd3,
        EV_TIMEOUT   = 3'd4,
        EV_DONE      = 3'd5
    } event_t;

    typedef enum logic {
        OP_HEARD = 1'b0,
        OP_SWEEP = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_PING_INTERVAL = 1'b0,
        REG_TIMEOUT_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] ping_interval;
        logic [TIME_W-1:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] seen;
    } slot_t;

    typedef struct packed {
        logic   load_item;
        logic   rd_issue;
        logic   idx_inc;
        logic   note_free;
        logic   write_refresh;
        logic   write_new;
        logic   clear_valid;
        logic   emit;
        logic   emit_last;
        event_t emit_ev;
    } cmd_t;

    typedef struct packed {
        logic op_sweep;
        logic cur_valid;
        logic idx_last;
        logic match;
        logic aged_out;
        logic ping_due;
        logic hit;
        logic free_found;
        logic out_free;
    } stat_t;

endpackage

### hw/rtl/ckat_if.sv
// stream interfaces for item requests and result events
// depends on ckat_pkg

interface ckat_req_if;
    import ckat_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] client_addr;
    logic [PORT_W-1:0] client_port;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output opcode, output client_addr, output client_port,
                    output now_time, input ready);
    modport sink   (input valid, input opcode, input client_addr, input client_port,
                    input now_time, output ready);
endinterface

interface ckat_rsp_if;
    import ckat_pkg::*;
    logic              valid;
    logic              ready;
    event_t            event_res;
    logic [ADDR_W-1:0] peer_addr;
    logic [PORT_W-1:0] peer_port;
    logic              last;

    modport source (output valid, output event_res, output peer_addr, output peer_port,
                    output last, input ready);
    modport sink   (input valid, input event_res, input peer_addr, input peer_port,
                    input last, output ready);
endinterface

### hw/rtl/ckat_regs.sv
// apb configuration registers: ping interval and timeout limit
// depends on ckat_pkg

module ckat_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ckat_pkg::PADDR_W-1:0]   paddr,
    input  logic [ckat_pkg::PDATA_W-1:0]   pwdata,
    output logic [ckat_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output ckat_pkg::cfg_t                 cfg
);
    import ckat_pkg::*;

    logic [TIME_W-1:0] ping_reg;
    logic [TIME_W-1:0] ping_next;
    logic [TIME_W-1:0] timeout_reg;
    logic [TIME_W-1:0] timeout_next;
    logic              wr_en;
    reg_idx_t          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        ping_next    = ping_reg;
        timeout_next = timeout_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PING_INTERVAL: ping_next    = pwdata;
                REG_TIMEOUT_LIMIT: timeout_next = pwdata;
                default:           ping_next    = ping_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PING_INTERVAL: prdata = ping_reg;
            REG_TIMEOUT_LIMIT: prdata = timeout_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ping_reg    <= PING_INTERVAL_RST;
            timeout_reg <= TIMEOUT_LIMIT_RST;
        end
        else
        begin
            ping_reg    <= ping_next;
            timeout_reg <= timeout_next;
        end
    end

    assign cfg.ping_interval = ping_reg;
    assign cfg.timeout_limit = timeout_reg;

endmodule

### hw/rtl/ckat_dp.sv
// datapath: item registers, slot memory, valid bits, age compare, output register
// depends on ckat_pkg; driven by ckat_ctrl commands

module ckat_dp #(
    parameter int TABLE_ENTRIES = ckat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ckat_pkg::cmd_t                cmd,
    output ckat_pkg::stat_t               stat,
    input  ckat_pkg::cfg_t                cfg,
    input  logic                          in_opcode,
    input  logic [ckat_pkg::ADDR_W-1:0]   in_addr,
    input  logic [ckat_pkg::PORT_W-1:0]   in_port,
    input  logic [ckat_pkg::TIME_W-1:0]   in_now,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ckat_pkg::event_t              out_event,
    output logic [ckat_pkg::ADDR_W-1:0]   out_addr,
    output logic [ckat_pkg::PORT_W-1:0]   out_port,
    output logic                          out_last
);
    import ckat_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_ENTRIES - 1);

    slot_t mem [TABLE_ENTRIES];

    logic                     op_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [PORT_W-1:0]        port_reg;
    logic [TIME_W-1:0]        now_reg;
    slot_t                    rd_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [IDX_W-1:0]         free_idx_next;
    logic                     free_found_reg;
    logic                     free_found_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    event_t                   out_event_reg;
    logic [ADDR_W-1:0]        out_addr_reg;
    logic [PORT_W-1:0]        out_port_reg;
    logic                     out_last_reg;
    logic [IDX_W-1:0]         wr_idx;
    logic [TIME_W-1:0]        age;
    logic                     out_free;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= in_opcode;
            addr_reg <= in_addr;
            port_reg <= in_port;
            now_reg  <= in_now;
        end
    end

    // slot memory, one write and one registered read
    assign wr_idx = cmd.write_new ? free_idx_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_new || cmd.write_refresh)
        begin
            mem[wr_idx] <= '{addr: addr_reg, port: port_reg, seen: now_reg};
        end
        if (cmd.rd_issue)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_comb
    begin
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        hit_next        = hit_reg;
        valid_next      = valid_reg;
        if (cmd.load_item)
        begin
            idx_next        = '0;
            free_found_next = 1'b0;
            hit_next        = 1'b0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.note_free && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_idx_next   = idx_reg;
        end
        if (cmd.write_refresh)
        begin
            hit_next = 1'b1;
        end
        if (cmd.write_new)
        begin
            valid_next[free_idx_reg] = 1'b1;
        end
        if (cmd.clear_valid)
        begin
            valid_next[idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            free_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            idx_reg        <= idx_next;
            free_idx_reg   <= free_idx_next;
            free_found_reg <= free_found_next;
            hit_reg        <= hit_next;
            valid_reg      <= valid_next;
        end
    end

    // modular age against the limits
    assign age = now_reg - rd_reg.seen;

    // output register
    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_event_reg <= cmd.emit_ev;
            out_last_reg  <= cmd.emit_last;
            case (cmd.emit_ev) inside
                EV_PING, EV_TIMEOUT:
                begin
                    out_addr_reg <= rd_reg.addr;
                    out_port_reg <= rd_reg.port;
                end
                EV_DONE:
                begin
                    out_addr_reg <= '0;
                    out_port_reg <= '0;
                end
                default:
                begin
                    out_addr_reg <= addr_reg;
                    out_port_reg <= port_reg;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;
    assign out_addr  = out_addr_reg;
    assign out_port  = out_port_reg;
    assign out_last  = out_last_reg;

    assign stat.op_sweep   = op_reg;
    assign stat.cur_valid  = valid_reg[idx_reg];
    assign stat.idx_last   = (idx_reg == IDX_MAX);
    assign stat.match      = (rd_reg.addr == addr_reg) && (rd_reg.port == port_reg);
    assign stat.aged_out   = age > cfg.timeout_limit;
    assign stat.ping_due   = age > cfg.ping_interval;
    assign stat.hit        = hit_reg;
    assign stat.free_found = free_found_reg;
    assign stat.out_free   = out_free;

`ifndef NO_ASSERTIONS
    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded over an untaken result");

    a_new_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> (free_found_reg && !valid_reg[free_idx_reg]))
        else $error("new entry written without a free slot");

    a_evict_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_valid |=> !valid_reg[$past(idx_reg)])
        else $error("evicted slot still valid");

    a_refresh_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_refresh |-> (stat.match && valid_reg[idx_reg] && !op_reg))
        else $error("refresh without a matching live entry");
`endif

endmodule

### hw/rtl/ckat_ctrl.sv
// controller state machine sequencing lookups, sweeps and result transfers
// depends on ckat_pkg; drives ckat_dp through cmd_t

module ckat_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ckat_pkg::stat_t  stat,
    output ckat_pkg::cmd_t   cmd
);
    import ckat_pkg::*;

    state_t state_reg;
    state_t state_next;
    event_t final_ev;

    always_comb
    begin
        if (stat.op_sweep)
        begin
            final_ev = EV_DONE;
        end
        else if (stat.hit)
        begin
            final_ev = EV_REFRESHED;
        end
        else if (stat.free_found)
        begin
            final_ev = EV_CONNECTED;
        end
        else
        begin
            final_ev = EV_DROPPED;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (stat.cur_valid)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = stat.idx_last ? ST_FINISH : ST_READ;
                end
            end
            ST_CHECK:
            begin
                if (!stat.op_sweep && stat.match)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.op_sweep && (stat.aged_out || stat.ping_due))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = stat.idx_last ? ST_FINISH : ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.idx_last ? ST_FINISH : ST_READ;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd         = '0;
        cmd.emit_ev = EV_DONE;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_READ:
            begin
                if (stat.cur_valid)
                begin
                    cmd.rd_issue = 1'b1;
                end
                else
                begin
                    cmd.note_free = !stat.op_sweep;
                    cmd.idx_inc   = !stat.idx_last;
                end
            end
            ST_CHECK:
            begin
                if (!stat.op_sweep && stat.match)
                begin
                    cmd.write_refresh = 1'b1;
                end
                else if (!(stat.op_sweep && (stat.aged_out || stat.ping_due)))
                begin
                    cmd.idx_inc = !stat.idx_last;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_ev     = stat.aged_out ? EV_TIMEOUT : EV_PING;
                    cmd.clear_valid = stat.aged_out;
                    cmd.idx_inc     = !stat.idx_last;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_ev   = final_ev;
                    cmd.write_new = (final_ev == EV_CONNECTED);
                end
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/client_keepalive_aging_table_top.sv
// top level of the client keepalive aging table
// depends on ckat_pkg, ckat_if, ckat_regs, ckat_dp, ckat_ctrl
//
// usage
// req carries one item per transfer: opcode heard (client_addr, client_port,
// now_time) or sweep (now_time only). rsp carries result transfers; last marks
// the final result of an item. a heard item gives exactly one result, a sweep
// gives one timed-out or ping result per aged entry and then a done result.
// items are handled one at a time: the slots are walked in index order,
// a free slot with a valid check only and a live slot with a registered
// memory read, then a compare. a refresh stops at the matching slot. the next
// item can be accepted in the cycle after the final result is loaded.
// req.ready is high only between items.
// rsp holds its result in an output register; while rsp.ready is low the walk
// pauses at the next result and the stored result stays stable.
// reset clears all valid marks and loads ping_interval 500, timeout_limit 5000;
// the apb port (register 0 at 0x0, register 1 at 0x4) is to be written
// only while idle; this binds the user, the block does not enforce it

module client_keepalive_aging_table_top #(
    parameter int TABLE_ENTRIES = ckat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ckat_req_if.sink                      req,
    ckat_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ckat_pkg::PADDR_W-1:0]  paddr,
    input  logic [ckat_pkg::PDATA_W-1:0]  pwdata,
    output logic [ckat_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ckat_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    ckat_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ckat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ckat_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg       (cfg),
        .in_opcode (req.opcode),
        .in_addr   (req.client_addr),
        .in_port   (req.client_port),
        .in_now    (req.now_time),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_event (rsp.event_res),
        .out_addr  (rsp.peer_addr),
        .out_port  (rsp.peer_port),
        .out_last  (rsp.last)
    );

endmodule
